// ===== design/hta_pkg.sv =====
package hta_pkg;

  localparam int ENTRIES    = 64;
  localparam int COUNT_BITS = 8;
  localparam int IDX_W      = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    KIND_CREATE = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_GET    = 3'd2,
    KIND_QUERY  = 3'd3,
    KIND_OPEN   = 3'd4,
    KIND_CLOSE  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  slot;
    logic [15:0] owner_id;
    logic [1:0]  owner_perm;
    logic [1:0]  others_perm;
  } hta_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_out;
    logic [15:0] owner_out;
    logic [1:0]  owner_perm_out;
    logic [1:0]  others_perm_out;
    logic        is_open;
  } hta_rsp_t;

  typedef struct packed {
    logic [15:0]           owner;
    logic [1:0]            owner_perm;
    logic [1:0]            others_perm;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

endpackage

// ===== design/handle_table_allocator.sv =====
// Sequence: a request accepted at one clock edge has its entry read at that
//   edge, is executed and written back in the S_EXEC state, and has its
//   response strobe registered at the end of that state.
// Accept: no new request is taken during the read-modify-write of the
//   single-port entry memory (S_EXEC); busy is high during the execute cycle.
// Reset: rst_n synchronous active low frees every entry at once (valid flops
//   cleared); entry memory contents are not cleared. The receiver cannot stall.
module handle_table_allocator
  import hta_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  hta_req_t in_req,
  output logic     out_valid,
  output hta_rsp_t out_rsp
);

  entry_t mem [ENTRIES];

  state_t               state_r, state_nxt;
  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  hta_req_t             req_r;
  entry_t               rd_r;
  logic [IDX_W-1:0]     free_idx_r, free_idx;
  logic                 full_r, full;
  logic                 out_valid_r, out_valid_nxt;
  hta_rsp_t             out_rsp_r, out_rsp_nxt;

  logic                 accept;
  logic [IDX_W-1:0]     idx;
  logic                 slot_ok;
  logic                 hit;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  entry_t               mem_wdata;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r == S_EXEC);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // lowest free entry
  always_comb begin
    free_idx = '0;
    full     = &valid_r;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idx     = IDX_W'(req_r.slot);
  assign slot_ok = 32'(req_r.slot) < ENTRIES;
  assign hit     = slot_ok && valid_r[idx] && (req_r.kind != KIND_CREATE) &&
                   (req_r.kind <= KIND_CLOSE);

  always_comb begin
    valid_nxt     = valid_r;
    mem_we        = 1'b0;
    mem_waddr     = idx;
    mem_wdata     = rd_r;
    out_valid_nxt = (state_r == S_EXEC);
    out_rsp_nxt   = '0;
    out_rsp_nxt.status   = ST_INVALID;
    out_rsp_nxt.slot_out = req_r.slot;
    if (state_r == S_EXEC) begin
      if (req_r.kind == KIND_CREATE) begin
        if (full_r) begin
          out_rsp_nxt.status   = ST_FULL;
          out_rsp_nxt.slot_out = '0;
        end else begin
          out_rsp_nxt.status     = ST_OK;
          out_rsp_nxt.slot_out   = 6'(free_idx_r);
          valid_nxt[free_idx_r]  = 1'b1;
          mem_we                 = 1'b1;
          mem_waddr              = free_idx_r;
          mem_wdata.owner        = req_r.owner_id;
          mem_wdata.owner_perm   = req_r.owner_perm;
          mem_wdata.others_perm  = req_r.others_perm;
          mem_wdata.count        = '0;
        end
      end else if (hit) begin
        out_rsp_nxt.status = ST_OK;
        case (req_r.kind)
          KIND_DELETE: valid_nxt[idx] = 1'b0;
          KIND_GET: begin
            out_rsp_nxt.owner_out       = rd_r.owner;
            out_rsp_nxt.owner_perm_out  = rd_r.owner_perm;
            out_rsp_nxt.others_perm_out = rd_r.others_perm;
          end
          KIND_QUERY: out_rsp_nxt.is_open = |rd_r.count;
          KIND_OPEN: begin
            mem_we = 1'b1;
            if (rd_r.count != '1) begin
              mem_wdata.count = rd_r.count + 1'b1;
            end
          end
          KIND_CLOSE: begin
            mem_we = 1'b1;
            if (rd_r.count != '0) begin
              mem_wdata.count = rd_r.count - 1'b1;
            end
          end
          default: mem_we = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
    if (accept) begin
      req_r      <= in_req;
      free_idx_r <= free_idx;
      full_r     <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= mem[IDX_W'(in_req.slot)];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

endmodule

// ===== design/hta_checker.sv =====
module hta_checker
  import hta_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input hta_rsp_t out_rsp
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && out_valid))
    else $error("busy longer than one cycle or missing response");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("response without request");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status != ST_OK)) |->
      (out_rsp.owner_out == '0 && out_rsp.owner_perm_out == '0 &&
       out_rsp.others_perm_out == '0 && !out_rsp.is_open))
    else $error("failed request returned data");

  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status == ST_FULL)) |-> (out_rsp.slot_out == '0))
    else $error("table full response carries a slot");

endmodule

bind handle_table_allocator hta_checker u_hta_checker (.*);
